@@ rtl/chto_pkg.sv @@
`timescale 1ns / 1ps
// types and codes shared by the chained hash table core
// no dependencies

package chto_pkg;

  localparam int unsigned KeyW     = 32;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned SlotW    = 7;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]          op;
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [SlotW-1:0]    slot;
    logic [PayloadW-1:0] found_payload;
  } rsp_t;

endpackage

@@ rtl/chained_hash_table_with_overflow_core.sv @@
`timescale 1ns / 1ps
// chained hash table with a separate overflow area, one entry memory
// depends on chto_pkg
//
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+--------------------------------
// request   | in        | start & !busy             | req_i  (op, key, payload)
// response  | out       | done_o strobe, one cycle  | rsp_o  (status, slot, found_payload)
//
// an operation reads one table entry per link visited on the chain, then
// registers the response; insert with a fresh overflow link visits one more
// entry. the walk is bound by the single read port of the entry memory, one
// link per cycle. when BUCKETS is not a power of two the home slot is reduced
// from the key two bits per radix-4 step before the walk. after reset the core sweeps
// the entry memory with busy high. the response cannot be stalled; the next
// request can be taken in the cycle of the strobe.

module chained_hash_table_with_overflow_core
  import chto_pkg::*;
#(
  parameter int unsigned BUCKETS        = 64,
  parameter int unsigned OVERFLOW_SLOTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned Total    = BUCKETS + OVERFLOW_SLOTS;
  localparam int unsigned SW       = $clog2(Total);
  localparam int unsigned BW       = $clog2(BUCKETS);
  localparam int unsigned RW       = BW + 2;
  localparam bit          IsPow2   = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam int unsigned HashLast = KeyW / 2 - 1;

  localparam logic [RW-1:0] ModB1   = RW'(BUCKETS);
  localparam logic [RW-1:0] ModB2   = RW'(2 * BUCKETS);
  localparam logic [SW:0]   FreeEnd = (SW + 1)'(Total);
  localparam logic [SW-1:0] LastIdx = SW'(Total - 1);
  localparam logic [SW:0]   FreeRst = (SW + 1)'(BUCKETS);

  typedef struct packed {
    logic [KeyW-1:0]     key;
    logic [PayloadW-1:0] payload;
    logic                valid;
    logic                nxt_vld;   // entry has a successor
    logic [SW-1:0]       nxt;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_CHECK
  } state_e;

  // entry memory, one write and one registered read port
  entry_t        mem [Total];
  entry_t        rd_q;
  logic          mem_we, mem_re;
  logic [SW-1:0] mem_waddr, mem_raddr;
  entry_t        mem_wdata;

  state_e          state_q, state_d;
  logic [SW-1:0]   cur_q, cur_d;      // slot being visited
  logic [SW:0]     free_q, free_d;    // next overflow slot to hand out
  logic [SW-1:0]   clr_q, clr_d;      // clearing sweep index
  req_t            req_q, req_d;
  logic [BW-1:0]   r_q, r_d;          // partial remainder of key mod BUCKETS
  logic [KeyW-1:0] kq_q, kq_d;        // key bits still to be reduced
  logic [3:0]      cnt_q, cnt_d;
  logic            done_q, done_d;
  rsp_t            rsp_q, rsp_d;

  // one radix-4 step of the remainder: r = (4r + d) mod BUCKETS
  logic [RW-1:0] t0, t1, t2;
  logic [BW-1:0] r_next;

  always_comb begin
    t0     = {r_q, kq_q[KeyW-1 -: 2]};
    t1     = (t0 >= ModB2) ? (t0 - ModB2) : t0;
    t2     = (t1 >= ModB1) ? (t1 - ModB1) : t1;
    r_next = t2[BW-1:0];
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    free_d    = free_q;
    clr_d     = clr_q;
    req_d     = req_q;
    r_d       = r_q;
    kq_d      = kq_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cur_q;
    mem_raddr = cur_q;
    mem_wdata = rd_q;

    case (state_q)
      ST_CLEAR: begin
        // sweep every entry to empty with no successor
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == LastIdx) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      ST_IDLE: begin
        if (start) begin
          req_d = req_i;
          if (req_i.op inside {OP_INSERT, OP_LOOKUP, OP_DELETE}) begin
            if (IsPow2) begin
              // home slot is a mask of the key, read it right away
              cur_d     = SW'(req_i.key[BW-1:0]);
              mem_re    = 1'b1;
              mem_raddr = cur_d;
              state_d   = ST_CHECK;
            end else begin
              r_d     = '0;
              kq_d    = req_i.key;
              cnt_d   = '0;
              state_d = ST_HASH;
            end
          end else begin
            // unused op code answers not found at once
            done_d = 1'b1;
            rsp_d  = '{status: STAT_NOT_FOUND, slot: '0, found_payload: '0};
          end
        end
      end

      ST_HASH: begin
        r_d   = r_next;
        kq_d  = kq_q << 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'(HashLast)) begin
          cur_d     = SW'(r_next);
          mem_re    = 1'b1;
          mem_raddr = cur_d;
          state_d   = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (req_q.op == OP_INSERT) begin
          if (rd_q.key == '0) begin
            // empty slot: store here, keep its successor link
            mem_we            = 1'b1;
            mem_wdata.key     = req_q.key;
            mem_wdata.payload = req_q.payload;
            mem_wdata.valid   = 1'b1;
            done_d            = 1'b1;
            rsp_d = '{status: STAT_OK, slot: SlotW'(cur_q), found_payload: '0};
            state_d           = ST_IDLE;
          end else if (rd_q.nxt_vld) begin
            cur_d     = rd_q.nxt;
            mem_re    = 1'b1;
            mem_raddr = rd_q.nxt;
          end else if (free_q >= FreeEnd) begin
            done_d  = 1'b1;
            rsp_d   = '{status: STAT_FULL, slot: '0, found_payload: '0};
            state_d = ST_IDLE;
          end else begin
            // link a fresh overflow slot at the tail and go on there
            mem_we            = 1'b1;
            mem_wdata.nxt_vld = 1'b1;
            mem_wdata.nxt     = free_q[SW-1:0];
            cur_d             = free_q[SW-1:0];
            mem_re            = 1'b1;
            mem_raddr         = free_q[SW-1:0];
            free_d            = free_q + 1'b1;
          end
        end else begin
          // lookup or delete: first key match ends the walk
          if (rd_q.key == req_q.key) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
            if (rd_q.valid) begin
              rsp_d = '{status: STAT_OK, slot: SlotW'(cur_q), found_payload: '0};
              if (req_q.op == OP_LOOKUP) begin
                rsp_d.found_payload = rd_q.payload;
              end else begin
                mem_we          = 1'b1;
                mem_wdata.valid = 1'b0;
              end
            end else begin
              rsp_d = '{status: STAT_NOT_FOUND, slot: '0, found_payload: '0};
            end
          end else if (rd_q.nxt_vld) begin
            cur_d     = rd_q.nxt;
            mem_re    = 1'b1;
            mem_raddr = rd_q.nxt;
          end else begin
            done_d  = 1'b1;
            rsp_d   = '{status: STAT_NOT_FOUND, slot: '0, found_payload: '0};
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  // control state and the registered done strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      free_q  <= FreeRst;
      clr_q   <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      clr_q   <= clr_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    req_q <= req_d;
    r_q   <= r_d;
    kq_q  <= kq_d;
    rsp_q <= rsp_d;
  end

`ifndef SYNTHESIS
  // a read never hits the entry written in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re && (mem_waddr == mem_raddr)))
    else $error("entry memory read and write collide");

  // free pointer stays within the overflow area
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q >= FreeRst) && (free_q <= FreeEnd))
    else $error("overflow free pointer out of range");

  // an accepted request keeps the core busy or answers in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted request lost");

  // no response while the memory is being cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !done_o)
    else $error("response during clearing sweep");
`endif

endmodule

@@ dv/chto_table_checker.sv @@
`timescale 1ns / 1ps
// response checker for the chained hash table core: keeps its own copy of the
// table, predicts every response and compares it with the one returned
// depends on chto_pkg

module chto_table_checker
  import chto_pkg::*;
#(
  parameter int unsigned BUCKETS        = 64,
  parameter int unsigned OVERFLOW_SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  logic        done_i,
  input  rsp_t        rsp_i,
  output int unsigned fails_o,
  output int unsigned pending_o
);

  localparam int unsigned TotalSlots = BUCKETS + OVERFLOW_SLOTS;
  localparam int          NoLink     = -1;

  logic [KeyW-1:0]     tbl_key     [TotalSlots];
  logic [PayloadW-1:0] tbl_payload [TotalSlots];
  logic                tbl_valid   [TotalSlots];
  logic [7:0]          tbl_next    [TotalSlots];
  int unsigned         free_slot;
  rsp_t                rsp_q [$];

  // links at or beyond the table end terminate the chain
  function automatic int link_of(int s);
    return (tbl_next[s] < TotalSlots) ? int'(tbl_next[s]) : NoLink;
  endfunction

  // applies one operation to the mirrored table, returns the response it yields
  function automatic rsp_t apply_table_op(req_t r);
    rsp_t res;
    int   s;
    int   n;
    int   hit;
    bit   placed;
    bit   full;
    res        = '0;
    res.status = STAT_NOT_FOUND;
    s          = int'(r.key % BUCKETS);
    placed     = 1'b0;
    full       = 1'b0;
    hit        = NoLink;
    case (r.op)
      OP_INSERT: begin
        for (int step = 0; step <= TotalSlots + 1; step++) begin
          if (tbl_key[s] == '0) begin
            placed = 1'b1;
            break;
          end
          n = link_of(s);
          if (n != NoLink) begin
            s = n;
            continue;
          end
          if (free_slot >= TotalSlots) begin
            full = 1'b1;
            break;
          end
          tbl_next[s] = 8'(free_slot);
          s           = int'(free_slot);
          free_slot++;
        end
        if (placed) begin
          tbl_key[s]     = r.key;
          tbl_payload[s] = r.payload;
          tbl_valid[s]   = 1'b1;
          res.status     = STAT_OK;
          res.slot       = SlotW'(s);
        end else if (full) begin
          res.status = STAT_FULL;
        end
      end
      OP_LOOKUP, OP_DELETE: begin
        // first key match on the chain decides, valid or not
        for (int step = 0; step <= TotalSlots; step++) begin
          if (tbl_key[s] == r.key) begin
            hit = s;
            break;
          end
          s = link_of(s);
          if (s == NoLink) break;
        end
        if (hit != NoLink && tbl_valid[hit]) begin
          res.status = STAT_OK;
          res.slot   = SlotW'(hit);
          if (r.op == OP_LOOKUP) res.found_payload = tbl_payload[hit];
          else tbl_valid[hit] = 1'b0;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int unsigned field_diff(string name, logic [PayloadW-1:0] want,
                                             logic [PayloadW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned errs;
    rsp_t        want;
    if (!rst_ni) begin
      for (int i = 0; i < TotalSlots; i++) begin
        tbl_key[i]     = '0;
        tbl_payload[i] = '0;
        tbl_valid[i]   = 1'b0;
        tbl_next[i]    = '1;
      end
      free_slot = BUCKETS;
      rsp_q.delete();
      fails_o   <= 0;
      pending_o <= 0;
    end else begin
      errs = 0;
      // response first: a request taken at this edge answers later
      if (done_i) begin
        if (rsp_q.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %0h", $time, rsp_i);
          errs++;
        end else begin
          want = rsp_q.pop_front();
          errs += field_diff("status", PayloadW'(want.status), PayloadW'(rsp_i.status));
          errs += field_diff("slot", PayloadW'(want.slot), PayloadW'(rsp_i.slot));
          errs += field_diff("found_payload", want.found_payload, rsp_i.found_payload);
        end
      end
      if (start_i && !busy_i) rsp_q.push_back(apply_table_op(req_i));
      fails_o   <= fails_o + errs;
      pending_o <= rsp_q.size();
    end
  end

endmodule

@@ dv/chained_hash_table_with_overflow_core_tb.sv @@
`timescale 1ns / 1ps
// testbench top for the chained hash table core: clock, reset, request stimulus
// depends on chto_pkg, chained_hash_table_with_overflow_core and chto_table_checker

module chained_hash_table_with_overflow_core_tb;
  import chto_pkg::*;

  localparam int unsigned Buckets       = 64;
  localparam int unsigned OverflowSlots = 64;
  // worst case is roughly a full-length chain walk per op plus sender gaps
  localparam int unsigned CycleLimit    = 1_500_000;
  // longest op: whole table walked; Buckets is a power of two, so no reduction
  localparam int unsigned DrainCycles   = 200;
  localparam int unsigned PhaseItems    = 396;
  localparam int unsigned PoolDepth     = 48;
  // the one op code the core does not define
  localparam logic [1:0]  OP_UNUSED     = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req;
  logic        done;
  rsp_t        rsp;
  int unsigned fails;
  int unsigned pending;

  // keys already sent as inserts, reused so lookups and deletes hit
  logic [KeyW-1:0] key_pool [$];

  chained_hash_table_with_overflow_core #(
    .BUCKETS       (Buckets),
    .OVERFLOW_SLOTS(OverflowSlots)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .req_i (req),
    .done_o(done),
    .rsp_o (rsp)
  );

  chto_table_checker #(
    .BUCKETS       (Buckets),
    .OVERFLOW_SLOTS(OverflowSlots)
  ) i_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_i   (busy),
    .req_i    (req),
    .done_i   (done),
    .rsp_i    (rsp),
    .fails_o  (fails),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic req_t mk_req(logic [1:0] op, logic [KeyW-1:0] key,
                                  logic [PayloadW-1:0] pl);
    req_t r;
    r.op      = op;
    r.key     = key;
    r.payload = pl;
    return r;
  endfunction

  // mostly well-formed traffic on a small key pool, some noise on top
  function automatic req_t random_req();
    logic [KeyW-1:0] k;
    logic [1:0]      op;
    int unsigned     roll;
    int unsigned     bucket;
    roll = $urandom_range(0, 99);
    // noise: any op code including the unused one, any key
    if (roll < 8) return mk_req(2'($urandom_range(0, 3)), $urandom(), {$urandom(), $urandom()});
    roll = $urandom_range(0, 99);
    if (roll < 32) op = OP_INSERT;
    else if (roll < 72) op = OP_LOOKUP;
    else op = OP_DELETE;
    if (key_pool.size() != 0 && (op != OP_INSERT || $urandom_range(0, 99) < 30)) begin
      // reuse a known key, duplicates on insert land deeper in the chain
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else if ($urandom_range(0, 99) < 3) begin
      k = '0;
    end else begin
      // a few hot buckets build long chains into the overflow area
      bucket = ($urandom_range(0, 99) < 60) ? $urandom_range(0, 3) * 17
                                            : $urandom_range(0, Buckets - 1);
      k = $urandom();
      k = k - (k % Buckets) + bucket;
      if (op == OP_INSERT && k != '0) begin
        if (key_pool.size() < PoolDepth) key_pool.push_back(k);
        else key_pool[$urandom_range(0, PoolDepth - 1)] = k;
      end
    end
    return mk_req(op, k, {$urandom(), $urandom()});
  endfunction

  // one request transfer, with random idle cycles in front of it
  task automatic send_req(input req_t r, input int unsigned idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // hold off the sender until every response has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned idle_pct;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req    <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table misses, unused op code
    send_req(mk_req(OP_LOOKUP, 32'd5, '0), 0);
    send_req(mk_req(OP_DELETE, 32'd5, '0), 0);
    send_req(mk_req(OP_UNUSED, 32'd5, '1), 0);
    // zero key is stored but leaves its slot free for the next insert
    send_req(mk_req(OP_INSERT, 32'd0, 64'h0123_4567_89ab_cdef), 0);
    send_req(mk_req(OP_LOOKUP, 32'd0, '0), 0);
    send_req(mk_req(OP_INSERT, 32'd64, 64'hfedc_ba98_7654_3210), 0);
    send_req(mk_req(OP_LOOKUP, 32'd0, '0), 0);
    // largest key twice: home slot, then the first overflow link
    send_req(mk_req(OP_INSERT, '1, '1), 0);
    send_req(mk_req(OP_INSERT, '1, '0), 0);
    send_req(mk_req(OP_LOOKUP, '1, '0), 0);
    // deleted first match hides the later duplicate
    send_req(mk_req(OP_DELETE, '1, '0), 0);
    send_req(mk_req(OP_LOOKUP, '1, '0), 0);
    send_req(mk_req(OP_DELETE, '1, '0), 0);
    // second collision on bucket zero, then a miss that walks the chain
    send_req(mk_req(OP_INSERT, 32'd128, 64'h8000_0000_0000_0001), 0);
    send_req(mk_req(OP_LOOKUP, 32'd128, '0), 0);
    send_req(mk_req(OP_LOOKUP, 32'd192, '0), 0);
    send_req(mk_req(OP_LOOKUP, 32'd64, '0), 0);
    key_pool.push_back('1);
    key_pool.push_back(32'd64);
    key_pool.push_back(32'd128);

    // random phases: back to back, sparse, moderate, back to back again;
    // the sender drains completely between phases
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1:       idle_pct = 71;
        2:       idle_pct = 29;
        default: idle_pct = 0;
      endcase
      repeat (PhaseItems) send_req(random_req(), idle_pct);
      wait_drained();
    end

    // catch any stray response after the last expected one
    repeat (DrainCycles) @(posedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("%0t: timeout after %0d cycles", $time, CycleLimit);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
